### rtl/pbd_pkg.sv
// Shared types and constants of the pulse beat detector.
package pbd_pkg;

  localparam int DIV_W  = 24;  // dividend and quotient width of the serial divider
  localparam int DVS_W  = 16;  // divisor width of the serial divider
  localparam int CNT_W  = $clog2(DIV_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PCT_W      = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_PULSE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_PULSE    = 3'd7;

  localparam logic [31:0]      STUCK_MS   = 32'd1200;
  localparam logic [DIV_W-1:0] MINUTE_MS  = 24'd60000;
  localparam logic [15:0]      SU_OFFSET  = 16'd2048;

  // Division by 100 as a multiplication by the reciprocal, exact for any 32-bit operand.
  localparam logic [31:0]      DIV100_MAGIC = 32'h51EB_851F;
  localparam int               DIV100_SHIFT = 37;
  localparam int               RC_W         = DIV_W + 32;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/pbd_div.sv
// Restoring serial divider, one quotient bit per cycle.
module pbd_div
  import pbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      quo_r  <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      cnt_r  <= CNT_W'(DIV_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r  <= {quo_r[DIV_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### rtl/pulse_beat_detector.sv
// Top level of the pulse beat detector: sequencer, stores and beat logic.
//
//  channel | direction | handshake            | contents
//  in_     | input     | in_tvalid/in_tready   | adc_sample, time_ms
//  out_    | output    | out_tvalid/out_tready | beat, rate_bpm, led_on, filtered, span, in_peak
//  cfg_    | input     | cfg_wr_en             | register index and write data
//
// An item is accepted only in the idle state, so the next waits for the whole sequence,
// set mostly by the serial division for the running mean; the three divisions by 100 use
// the reciprocal unit, each in its own state. A window rescan adds a pass over the window,
// and a beat whose interval is averaged adds the interval sum and two more serial divisions.
// Reset clears all control state at once; the mean store needs no clearing pass.
// A result that waits for out_tready holds the next item in its last step, and in_tready
// stays low until that item's result is registered.
module pulse_beat_detector
  import pbd_pkg::*;
#(
  parameter int WINDOW_DEPTH   = 104,
  parameter int RATE_AVG_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // adc_sample[11:0], time_ms[43:12], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // beat[0], rate_bpm[16:1], led_on[17], filtered[30:18], span[46:31], in_peak[47]
  output logic [47:0]           out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = 12 + FW;
  localparam int RAW  = (RATE_AVG_DEPTH > 1) ? $clog2(RATE_AVG_DEPTH) : 1;
  localparam int RCW  = $clog2(RATE_AVG_DEPTH + 1);
  localparam int ISW  = 16 + RCW;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_MEAN, S_MDIV, S_SDIV, S_WIN, S_SCAN, S_THI,
    S_HDIV, S_LDIV, S_DETECT, S_SUM, S_ADIV, S_RDIV, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [PCT_W-1:0] high_pct_r, low_pct_r;
  logic [15:0] min_span_r, refractory_r, int_min_r, int_max_r, no_pulse_r, led_pulse_r;

  // item latch
  logic [11:0] raw_r;
  logic [31:0] now_r;

  // stores
  logic [11:0] mean_mem [WINDOW_DEPTH];
  logic [15:0] win_mem  [WINDOW_DEPTH];
  logic [11:0] mean_rd_r;
  logic [15:0] win_rd_r;
  logic [AW-1:0] win_addr;
  logic [15:0] interval_r [RATE_AVG_DEPTH];

  // block state
  logic [SUMW-1:0] mean_sum_r;
  logic [AW-1:0]   ptr_r;
  logic [FW-1:0]   fill_r;
  logic signed [12:0] smooth_r;
  logic [15:0] low_r, high_r, thi_r, tlo_r;
  logic [FW-1:0] scan_r;
  logic        falling_r;
  logic signed [13:0] cand_r;
  logic [31:0] cand_time_r, last_beat_r, prior_beat_r, led_off_r;
  logic        led_r;
  logic [RCW-1:0] icount_r;
  logic [RAW-1:0] iptr_r, ik_r;
  logic [ISW-1:0] isum_r;
  logic [15:0] rate_r;
  logic        beat_r;
  logic        neg_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic             div_go_r;
  logic [DIV_W-1:0] div_a_r;
  logic [DVS_W-1:0] div_b_r;

  // reciprocal unit for the divisions by 100
  logic [DIV_W-1:0]             rc_a_r;
  logic [RC_W-1:0]              rc_prod;
  logic [RC_W-1-DIV100_SHIFT:0] rc_q;

  assign div_req.start    = div_go_r;
  assign div_req.dividend = div_a_r;
  assign div_req.divisor  = div_b_r;

  pbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // combinational helpers
  logic [FW-1:0]   fill_inc;
  logic [SUMW-1:0] mean_old, mean_sum_nxt;
  logic signed [12:0] xdc;
  logic signed [20:0] prod;
  logic [19:0] prod_mag;
  logic [15:0] su, span, w_low, w_high, scan_low, scan_high;
  logic        was_full, rescan;
  logic signed [13:0] sig_ext;
  logic        no_pulse, acc, fall_nxt, rate_upd;
  logic [31:0] prior_eff, rr, ctime_nxt, last_nxt, off_a, off_nxt;
  logic signed [13:0] cand_nxt;
  logic        led_nxt;
  logic [ISW-1:0] isum_nxt;
  logic [RCW-1:0] icount_nxt;

  always_comb begin
    rc_prod = RC_W'(rc_a_r) * RC_W'(DIV100_MAGIC);
    rc_q    = rc_prod[RC_W-1:DIV100_SHIFT];

    fill_inc     = (fill_r < FW'(WINDOW_DEPTH)) ? fill_r + 1'b1 : fill_r;
    mean_old     = (fill_r < FW'(WINDOW_DEPTH)) ? '0 : SUMW'(mean_rd_r);
    mean_sum_nxt = mean_sum_r - mean_old + SUMW'(raw_r);
    xdc          = signed'({1'b0, raw_r}) - signed'({1'b0, div_rsp.quotient[11:0]});
    prod         = 21'(smooth_r) * 21'sd85 + 21'(xdc) * 21'sd15;
    prod_mag     = prod[20] ? 20'(-prod) : prod[19:0];

    su       = 16'(smooth_r) + SU_OFFSET;
    was_full = (fill_r >= FW'(WINDOW_DEPTH));
    rescan   = was_full && ((win_rd_r == low_r) || (win_rd_r == high_r));
    w_low    = (su < low_r) ? su : low_r;
    w_high   = (su > high_r) ? su : high_r;
    scan_low  = (win_rd_r < low_r) ? win_rd_r : low_r;
    scan_high = (win_rd_r > high_r) ? win_rd_r : high_r;
    span     = high_r - low_r;

    // beat detector on the finished sample
    sig_ext   = 14'(smooth_r);
    no_pulse  = (now_r - last_beat_r) > 32'(no_pulse_r);
    prior_eff = no_pulse ? '0 : prior_beat_r;
    acc       = 1'b0;
    fall_nxt  = falling_r;
    cand_nxt  = cand_r;
    ctime_nxt = cand_time_r;
    last_nxt  = last_beat_r;
    if (!falling_r) begin
      cand_nxt = 14'sh2000;
      if ((span >= min_span_r) && (su >= thi_r)) begin
        fall_nxt  = 1'b1;
        cand_nxt  = sig_ext;
        ctime_nxt = now_r;
      end
    end else begin
      if (sig_ext > cand_r) begin
        cand_nxt  = sig_ext;
        ctime_nxt = now_r;
      end
      if (su <= tlo_r) begin
        if ((now_r - last_beat_r) > 32'(refractory_r)) begin
          acc      = 1'b1;
          last_nxt = now_r;
        end
        fall_nxt = 1'b0;
      end
      if ((now_r - ctime_nxt) > STUCK_MS) fall_nxt = 1'b0;
    end
    rr       = now_r - prior_eff;
    rate_upd = acc && (prior_eff != '0) && (rr >= 32'(int_min_r)) && (rr <= 32'(int_max_r));

    // the indicator deadline is compared directly with the time stamp
    off_a   = acc ? now_r + 32'(led_pulse_r) : led_off_r;
    led_nxt = acc ? 1'b1 : led_r;
    off_nxt = off_a;
    if ((off_a != '0) && (now_r >= off_a)) begin
      led_nxt = 1'b0;
      off_nxt = '0;
    end

    icount_nxt = (icount_r < RCW'(RATE_AVG_DEPTH)) ? icount_r + 1'b1 : icount_r;
    isum_nxt   = isum_r + ISW'(interval_r[ik_r]);
    win_addr   = (state_r == S_SCAN && scan_r < FW'(WINDOW_DEPTH)) ? scan_r[AW-1:0] : ptr_r;
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_MEAN) mean_mem[ptr_r] <= raw_r;
    mean_rd_r <= mean_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WIN) win_mem[ptr_r] <= su;
    win_rd_r <= win_mem[win_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pct_r   <= 7'd65;
      low_pct_r    <= 7'd45;
      min_span_r   <= 16'd40;
      refractory_r <= 16'd330;
      int_min_r    <= 16'd350;
      int_max_r    <= 16'd2000;
      no_pulse_r   <= 16'd2000;
      led_pulse_r  <= 16'd30;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HIGH_PCT:     high_pct_r   <= cfg_wdata[PCT_W-1:0];
        CFG_LOW_PCT:      low_pct_r    <= cfg_wdata[PCT_W-1:0];
        CFG_MIN_SPAN:     min_span_r   <= cfg_wdata;
        CFG_REFRACTORY:   refractory_r <= cfg_wdata;
        CFG_INTERVAL_MIN: int_min_r    <= cfg_wdata;
        CFG_INTERVAL_MAX: int_max_r    <= cfg_wdata;
        CFG_NO_PULSE:     no_pulse_r   <= cfg_wdata;
        CFG_LED_PULSE:    led_pulse_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_go_r     <= 1'b0;
      mean_sum_r   <= '0;
      ptr_r        <= '0;
      fill_r       <= '0;
      smooth_r     <= '0;
      low_r        <= 16'hFFFF;
      high_r       <= '0;
      falling_r    <= 1'b0;
      cand_r       <= 14'sh2000;
      cand_time_r  <= '0;
      last_beat_r  <= '0;
      prior_beat_r <= '0;
      icount_r     <= '0;
      iptr_r       <= '0;
      rate_r       <= '0;
      led_off_r    <= '0;
      led_r        <= 1'b0;
      beat_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // the last step reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_r   <= in_tdata[11:0];
            now_r   <= in_tdata[43:12];
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_MEAN;
        S_MEAN: begin
          mean_sum_r <= mean_sum_nxt;
          div_a_r    <= DIV_W'(mean_sum_nxt);
          div_b_r    <= DVS_W'(fill_inc);
          div_go_r   <= 1'b1;
          state_r    <= S_MDIV;
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            neg_r   <= prod[20];
            rc_a_r  <= DIV_W'(prod_mag);
            state_r <= S_SDIV;
          end else begin
            div_go_r <= 1'b0;
          end
        end
        S_SDIV: begin
          smooth_r <= neg_r ? -signed'(rc_q[12:0]) : signed'(rc_q[12:0]);
          state_r  <= S_WIN;
        end
        S_WIN: begin
          ptr_r  <= (ptr_r == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
          fill_r <= fill_inc;
          if (rescan) begin
            low_r   <= 16'hFFFF;
            high_r  <= '0;
            scan_r  <= '0;
            state_r <= S_SCAN;
          end else begin
            low_r   <= w_low;
            high_r  <= w_high;
            state_r <= S_THI;
          end
        end
        S_SCAN: begin
          // the registered read data lags the scan address
          if (scan_r != '0) begin
            low_r  <= scan_low;
            high_r <= scan_high;
          end
          if (scan_r == FW'(WINDOW_DEPTH)) state_r <= S_THI;
          else scan_r <= scan_r + 1'b1;
        end
        S_THI: begin
          rc_a_r  <= DIV_W'(span) * DIV_W'(high_pct_r);
          state_r <= S_HDIV;
        end
        S_HDIV: begin
          thi_r   <= low_r + rc_q[15:0];
          rc_a_r  <= DIV_W'(span) * DIV_W'(low_pct_r);
          state_r <= S_LDIV;
        end
        S_LDIV: begin
          tlo_r   <= low_r + rc_q[15:0];
          state_r <= S_DETECT;
        end
        S_DETECT: begin
          falling_r    <= fall_nxt;
          cand_r       <= cand_nxt;
          cand_time_r  <= ctime_nxt;
          last_beat_r  <= last_nxt;
          prior_beat_r <= acc ? now_r : prior_eff;
          if (no_pulse) rate_r <= '0;
          led_r        <= led_nxt;
          led_off_r    <= off_nxt;
          beat_r       <= acc;
          if (rate_upd) begin
            interval_r[iptr_r] <= rr[15:0];
            iptr_r   <= (iptr_r == RAW'(RATE_AVG_DEPTH - 1)) ? '0 : iptr_r + 1'b1;
            icount_r <= icount_nxt;
            isum_r   <= '0;
            ik_r     <= '0;
            state_r  <= S_SUM;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SUM: begin
          isum_r <= isum_nxt;
          ik_r   <= ik_r + 1'b1;
          if (RCW'(ik_r) == icount_r - 1'b1) begin
            div_a_r  <= DIV_W'(isum_nxt);
            div_b_r  <= DVS_W'(icount_r);
            div_go_r <= 1'b1;
            state_r  <= S_ADIV;
          end
        end
        S_ADIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient[15:0] == '0) begin
              rate_r  <= '0;
              state_r <= S_DONE;
            end else begin
              div_a_r  <= MINUTE_MS;
              div_b_r  <= div_rsp.quotient[15:0];
              div_go_r <= 1'b1;
              state_r  <= S_RDIV;
            end
          end else begin
            div_go_r <= 1'b0;
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            rate_r  <= div_rsp.quotient[15:0];
            state_r <= S_DONE;
          end else begin
            div_go_r <= 1'b0;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {falling_r, span, smooth_r, led_r, rate_r, beat_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
